>>> sv/qbvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_pkg: shared types and constants for the quad batch vertex setup block
// Field widths, operation and result kind codes, the sine table and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package qbvs_pkg;

	localparam int MaxQuads = 8192;
	localparam int MaxSlots = 32;
	localparam int SlotW    = 5;
	localparam int UsedW    = 6;
	localparam int QuadW    = 14;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_BIND   = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] size_x;
		logic [31:0] size_y;
		logic [15:0] angle;
		logic [31:0] color_rgba;
		logic [31:0] texture_id;
		logic [15:0] tiling;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] vert_x;
		logic [31:0] vert_y;
		logic [31:0] vert_z;
		logic [1:0]  corner;
		logic [31:0] vert_color;
		logic [4:0]  slot;
		logic [15:0] vert_tiling;
		logic [31:0] bound_texture;
		logic [15:0] index_count;
		logic        last;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic             load;      // capture the input item, start trig
		logic             restart;   // begin a new batch
		logic             alloc;     // write texture into the new slot
		logic             quad_inc;  // one more quad in the batch
		logic             emit_bind;
		logic             emit_draw;
		logic             emit_vert;
		logic [SlotW-1:0] bind_slot;
		logic [1:0]       corner;
		logic             last;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [UsedW-1:0] slots_used;
		logic             batch_full;
		logic             hit;        // texture found (or white)
		logic             out_busy;   // output register full and not taken
	} stat_t;

	localparam logic [15:0] SINE_TAB [65] = '{
		16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
		16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
		16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151,
		16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788,
		16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812,
		16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106,
		16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572,
		16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
		16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
		16'd32768
	};

	// Quarter-wave sine in Q1.15, interpolated on the low eight angle bits.
	function automatic logic signed [17:0] sine_q15(input logic [15:0] a);
		logic [14:0] p;
		logic [6:0]  idx;
		logic [7:0]  frac;
		logic [15:0] d;
		logic [23:0] prod;
		logic [16:0] v;
		p = a[14] ? (15'h4000 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		idx = p[14:8];
		frac = p[7:0];
		if (idx >= 7'd64) begin
			v = {1'b0, SINE_TAB[64]};
		end else begin
			d = SINE_TAB[idx + 7'd1] - SINE_TAB[idx];
			prod = d * frac + 24'd128;
			v = {1'b0, SINE_TAB[idx]} + {1'b0, prod[23:8]};
		end
		sine_q15 = a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

>>> sv/qbvs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_if: valid/ready channel
// Carries one payload of a given type with a source and a sink modport.
// ----------------------------------------------------------------------------
interface qbvs_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/qbvs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_ctrl: sequencer for the quad batcher
// Decodes each transaction and steps through flush binds, the draw call and
// the four vertices, one result per cycle whenever the output is free.
// ----------------------------------------------------------------------------
module qbvs_ctrl import qbvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_BIND  = 3'd2;
	localparam logic [2:0] ST_DRAW  = 3'd3;
	localparam logic [2:0] ST_SLOT  = 3'd4;
	localparam logic [2:0] ST_VERT  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic             is_end_q, is_end_d;
	logic [SlotW-1:0] idx_q, idx_d;
	logic [1:0]       crn_q, crn_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		is_end_d = is_end_q;
		idx_d = idx_q;
		crn_d = crn_q;
		cmd = '0;
		cmd.bind_slot = idx_q;
		cmd.corner = crn_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					is_end_d = (in_op == OP_END);
					idx_d = '0;
					crn_d = '0;
					if (in_op == OP_BEGIN) begin
						cmd.restart = 1'b1;
					end else if (in_op == OP_DRAW) begin
						state_d = ST_CHECK;
					end else if (in_op == OP_END) begin
						state_d = ST_BIND;
					end
				end
			end
			ST_CHECK: begin
				state_d = stat.batch_full ? ST_BIND : ST_SLOT;
			end
			ST_BIND: begin
				if (!stat.out_busy) begin
					cmd.emit_bind = 1'b1;
					idx_d = idx_q + 1'b1;
					if ({1'b0, idx_q} + 6'd1 >= stat.slots_used || idx_q == 5'd31) begin
						state_d = ST_DRAW;
					end
				end
			end
			ST_DRAW: begin
				if (!stat.out_busy) begin
					cmd.emit_draw = 1'b1;
					cmd.last = is_end_q;
					if (is_end_q) begin
						state_d = ST_IDLE;
					end else begin
						// The lookup has to be redone against the emptied batch.
						cmd.restart = 1'b1;
						state_d = ST_CHECK;
					end
				end
			end
			ST_SLOT: begin
				// Lookup compare is registered on entry; allocate on a miss.
				cmd.alloc = !stat.hit;
				state_d = ST_VERT;
			end
			ST_VERT: begin
				if (!stat.out_busy) begin
					cmd.emit_vert = 1'b1;
					crn_d = crn_q + 2'd1;
					if (crn_q == 2'd3) begin
						cmd.last = 1'b1;
						cmd.quad_inc = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			is_end_q <= 1'b0;
			idx_q <= '0;
			crn_q <= '0;
		end else begin
			state_q <= state_d;
			is_end_q <= is_end_d;
			idx_q <= idx_d;
			crn_q <= crn_d;
		end
	end

endmodule

>>> sv/qbvs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_dp: datapath of the quad batcher
// Slot table with parallel compare, batch counters, the rotation products
// and the output register.
// ----------------------------------------------------------------------------
module qbvs_dp import qbvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output stat_t     stat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [31:0]      slot_tab_q [MaxSlots];
	logic [UsedW-1:0] used_q;
	logic [QuadW-1:0] quads_q;
	in_item_t         item_q;
	logic signed [17:0] sin_q, cos_q;
	logic [SlotW-1:0] slot_q;
	logic             hit_q;
	logic             valid_q;
	out_item_t        out_q;
	out_item_t        out_d;

	// Per corner products, registered before the sums.
	logic signed [49:0] xc_q, ys_q, xs_q, yc_q;

	logic             hit_c;
	logic [SlotW-1:0] hit_slot_c;

	always_comb begin
		hit_c = (item_q.texture_id == 32'd0);
		hit_slot_c = '0;
		for (int i = MaxSlots - 1; i >= 1; i--) begin
			if (i < used_q && slot_tab_q[i] == item_q.texture_id && item_q.texture_id != 0) begin
				hit_c = 1'b1;
				hit_slot_c = SlotW'(i);
			end
		end
	end

	assign stat.slots_used = used_q;
	assign stat.batch_full = (quads_q >= QuadW'(MaxQuads)) || (used_q >= UsedW'(MaxSlots));
	assign stat.hit = hit_q;
	assign stat.out_busy = valid_q && !out_ready;
	assign out_valid = valid_q;
	assign out_data = out_q;

	// Signed corner lengths for the corner being set up next.
	logic        ncx, ncy;
	logic [1:0]  pcorner;
	logic signed [32:0] lx, ly;
	assign pcorner = cmd.emit_vert ? cmd.corner + 2'd1 : cmd.corner;
	assign ncx = (pcorner == 2'd0) || (pcorner == 2'd3);
	assign ncy = (pcorner == 2'd0) || (pcorner == 2'd1);
	assign lx = ncx ? -$signed({item_q.size_x[31], item_q.size_x})
		: $signed({item_q.size_x[31], item_q.size_x});
	assign ly = ncy ? -$signed({item_q.size_y[31], item_q.size_y})
		: $signed({item_q.size_y[31], item_q.size_y});

	logic signed [51:0] sx, sy;
	logic signed [35:0] rx, ry;
	logic signed [36:0] vx, vy;
	assign sx = 52'(xc_q) - 52'(ys_q) + 52'sd32768;
	assign sy = 52'(xs_q) + 52'(yc_q) + 52'sd32768;
	assign rx = sx[51:16];
	assign ry = sy[51:16];
	assign vx = 37'($signed(item_q.pos_x)) + 37'(rx);
	assign vy = 37'($signed(item_q.pos_y)) + 37'(ry);

	function automatic logic [31:0] sat32(input logic signed [36:0] v);
		if (v > 37'sd2147483647) sat32 = 32'h7FFF_FFFF;
		else if (v < -37'sd2147483648) sat32 = 32'h8000_0000;
		else sat32 = v[31:0];
	endfunction

	logic [18:0] icount;
	assign icount = 19'(quads_q) * 19'd6;

	always_comb begin
		out_d = '0;
		out_d.last = cmd.last;
		if (cmd.emit_bind) begin
			out_d.kind = KIND_BIND;
			out_d.slot = cmd.bind_slot;
			out_d.bound_texture = (cmd.bind_slot == '0) ? 32'd0
				: slot_tab_q[cmd.bind_slot];
		end else if (cmd.emit_draw) begin
			out_d.kind = KIND_DRAW;
			out_d.index_count = (icount > 19'd65535) ? 16'hFFFF : icount[15:0];
		end else begin
			out_d.kind = KIND_VERTEX;
			out_d.vert_x = sat32(vx);
			out_d.vert_y = sat32(vy);
			out_d.vert_z = item_q.pos_z;
			out_d.corner = cmd.corner;
			out_d.vert_color = item_q.color_rgba;
			out_d.slot = slot_q;
			out_d.vert_tiling = item_q.tiling;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			sin_q <= sine_q15(in_data.angle);
			cos_q <= sine_q15(in_data.angle + 16'h4000);
		end
		hit_q <= hit_c;
		if (cmd.alloc) begin
			slot_tab_q[used_q[SlotW-1:0]] <= item_q.texture_id;
			slot_q <= used_q[SlotW-1:0];
		end else if (hit_q && !cmd.emit_vert && !cmd.quad_inc) begin
			slot_q <= hit_slot_c;
		end
		if (!cmd.emit_vert || !cmd.last) begin
			xc_q <= lx * cos_q;
			ys_q <= ly * sin_q;
			xs_q <= lx * sin_q;
			yc_q <= ly * cos_q;
		end
		if (cmd.emit_bind || cmd.emit_draw || cmd.emit_vert) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= UsedW'(1);
			quads_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				used_q <= UsedW'(1);
				quads_q <= '0;
			end else begin
				if (cmd.alloc) used_q <= used_q + 1'b1;
				if (cmd.quad_inc) quads_q <= quads_q + 1'b1;
			end
			if (cmd.emit_bind || cmd.emit_draw || cmd.emit_vert) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/quad_batch_vertex_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_batch_vertex_setup: sprite quad batcher with texture slots
// Turns begin, draw and end transactions into vertex, bind and draw results.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in       in   op, position, size, angle, colour, texture, tiling
//  out      out  kind, vertex fields, slot, bound texture, index count, last
//
// A begin is handled at decode. A draw steps through decode, slot lookup,
// allocate, then four vertices at one a cycle while the output register is
// free. A flush emits one bind per used slot, then the draw call; a flush
// forced inside a draw then redoes the lookup on the new batch.
// Reset empties the batch; unwritten slot entries hold no defined value.
// A stalled output register holds the sequencer in place.
module quad_batch_vertex_setup import qbvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	qbvs_if.sink   in,
	qbvs_if.source out
);

	cmd_t  cmd;
	stat_t stat;
	in_item_t in_item;
	out_item_t out_item;

	assign in_item = in.data;
	assign out.data = out_item;

	qbvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_op    (in_item.op),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qbvs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.out_data  (out_item)
	);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quad_batch_vertex_setup
// Directed and random begin, draw and end transactions are driven in bursts.
// Vertex, bind and draw-call results are predicted in the bench and compared
// field by field while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
	import qbvs_pkg::*;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_NONE = 2'd3;

	logic clk;
	logic arst_n;

	qbvs_if #(.T(in_item_t))  in_ch ();
	qbvs_if #(.T(out_item_t)) out_ch ();

	quad_batch_vertex_setup uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_ch.sink),
		.out   (out_ch.source)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	in_item_t  pending[$];
	out_item_t expected[$];
	logic [31:0] tex_of_slot [32];
	int unsigned used_slots;
	int unsigned quad_count;
	int unsigned errors;
	int unsigned checked;
	int unsigned quads_sent;
	int unsigned flushes_sent;
	longint unsigned cycles;
	bit stim_done;
	int burst_left;
	int gap_left;
	int stall_phase;

	localparam logic [15:0] QSINE [65] = '{
		0, 804, 1608, 2411, 3212, 4011, 4808, 5602, 6393, 7180, 7962, 8740,
		9512, 10279, 11039, 11793, 12540, 13279, 14010, 14733, 15447, 16151,
		16846, 17531, 18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
		23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791, 27246, 27684,
		28106, 28511, 28899, 29269, 29622, 29957, 30274, 30572, 30853, 31114,
		31357, 31581, 31786, 31972, 32138, 32286, 32413, 32522, 32610, 32679,
		32729, 32758, 32768
	};

	function automatic longint angle_sine(input logic [15:0] a);
		int unsigned p, idx, frac, d;
		longint v;
		p = a[13:0];
		if (a[14]) p = 16384 - p;
		idx = p >> 8;
		frac = p & 255;
		if (idx >= 64) v = 32768;
		else begin
			d = QSINE[idx + 1] - QSINE[idx];
			v = QSINE[idx] + ((d * frac + 128) >> 8);
		end
		return a[15] ? -v : v;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic push_flush(input bit final_one);
		out_item_t r;
		int unsigned n;
		for (int i = 0; i < used_slots && i < 32; i++) begin
			r = '0;
			r.kind = KIND_BIND;
			r.slot = i[4:0];
			r.bound_texture = tex_of_slot[i];
			expected.push_back(r);
		end
		n = quad_count * 6;
		if (n > 65535) n = 65535;
		r = '0;
		r.kind = KIND_DRAW;
		r.index_count = n[15:0];
		r.last = final_one;
		expected.push_back(r);
	endtask

	task automatic predict_batch(input in_item_t it);
		out_item_t r;
		int unsigned slot;
		longint s, c, lx, ly, px, py, sx, sy, t;
		if (it.op == OP_BEGIN) begin
			used_slots = 1;
			quad_count = 0;
			return;
		end
		if (it.op == OP_END) begin
			push_flush(1'b1);
			return;
		end
		if (it.op != OP_DRAW) return;
		if (quad_count >= MaxQuads || used_slots >= MaxSlots) begin
			push_flush(1'b0);
			used_slots = 1;
			quad_count = 0;
		end
		slot = 0;
		if (it.texture_id != 0) begin
			for (int i = 1; i < used_slots; i++)
				if (slot == 0 && tex_of_slot[i] == it.texture_id) slot = i;
			if (slot == 0) begin
				slot = used_slots;
				tex_of_slot[slot] = it.texture_id;
				used_slots++;
			end
		end
		s = angle_sine(it.angle);
		c = angle_sine(it.angle + 16'h4000);
		px = $signed(it.pos_x);
		py = $signed(it.pos_y);
		sx = $signed(it.size_x);
		sy = $signed(it.size_y);
		for (int k = 0; k < 4; k++) begin
			lx = (k == 0 || k == 3) ? -sx : sx;
			ly = (k < 2) ? -sy : sy;
			r = '0;
			r.kind = KIND_VERTEX;
			t = (lx * c - ly * s + 32768) >>> 16;
			r.vert_x = clamp32(px + t);
			t = (lx * s + ly * c + 32768) >>> 16;
			r.vert_y = clamp32(py + t);
			r.vert_z = it.pos_z;
			r.corner = k[1:0];
			r.vert_color = it.color_rgba;
			r.slot = slot[4:0];
			r.vert_tiling = it.tiling;
			r.last = (k == 3);
			expected.push_back(r);
		end
		quad_count = (quad_count + 1) & 16'h3fff;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
	endtask

	function automatic in_item_t make_quad(input logic [31:0] tex);
		in_item_t it;
		it.op = OP_DRAW;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		case ($urandom_range(0, 3))
			0: begin it.size_x = $urandom; it.size_y = $urandom; end
			default: begin
				it.size_x = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
				it.size_y = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			end
		endcase
		if ($urandom_range(0, 1)) begin
			it.pos_x = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			it.pos_y = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		end
		it.angle = 16'($urandom);
		it.color_rgba = $urandom;
		it.texture_id = tex;
		it.tiling = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_op(input logic [1:0] op);
		in_item_t it;
		it = make_quad($urandom);
		it.op = op;
		return it;
	endfunction

	// Directed items, then random batches drawn from a small texture pool
	// so that lookups hit as well as allocate.
	initial begin
		in_item_t it;
		logic [31:0] pool [8];
		pending.push_back(make_op(OP_END));
		it = make_quad(0);
		it.pos_x = 32'h7fff_ffff; it.pos_y = 32'h8000_0000;
		it.size_x = 32'h7fff_ffff; it.size_y = 32'h7fff_ffff; it.angle = 16'd0;
		it.pos_z = 32'hffff_ffff; it.color_rgba = 32'hffff_ffff; it.tiling = 16'hffff;
		pending.push_back(it);
		it = make_quad(32'hffff_ffff);
		it.pos_x = 32'h8000_0000; it.pos_y = 32'h7fff_ffff;
		it.size_x = 32'h8000_0000; it.size_y = 32'h8000_0000; it.angle = 16'hffff;
		it.pos_z = 0; it.color_rgba = 0; it.tiling = 16'd0;
		pending.push_back(it);
		for (int a = 0; a < 4; a++) begin
			it = make_quad(32'h1);
			it.size_x = 32'h0001_0000; it.size_y = 32'h0002_0000;
			it.pos_x = 0; it.pos_y = 0;
			it.angle = 16'(a * 16384 + (a == 3 ? 128 : 0));
			pending.push_back(it);
		end
		pending.push_back(make_op(OP_NONE));
		pending.push_back(make_op(OP_END));
		pending.push_back(make_quad(32'h2));
		pending.push_back(make_op(OP_END));
		pending.push_back(make_op(OP_BEGIN));
		pending.push_back(make_op(OP_END));
		// fill all slots to force a flush inside a draw
		pending.push_back(make_op(OP_BEGIN));
		for (int i = 0; i < 33; i++) pending.push_back(make_quad(32'h100 + i));
		pending.push_back(make_op(OP_END));
		for (int i = 0; i < 8; i++) pool[i] = $urandom;
		for (int n = 0; n < 300; n++) begin
			case ($urandom_range(0, 19))
				0: pending.push_back(make_op(OP_BEGIN));
				1, 2: pending.push_back(make_op(OP_END));
				3: pending.push_back(make_op(OP_NONE));
				4: pending.push_back(make_quad(0));
				5, 6: pending.push_back(make_quad($urandom));
				default: pending.push_back(make_quad(pool[$urandom_range(0, 7)]));
			endcase
		end
		pending.push_back(make_op(OP_END));
	end

	// Driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_batch(in_ch.data);
				if (in_ch.data.op == OP_DRAW) quads_sent++;
				if (in_ch.data.op == OP_END) flushes_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					in_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_ch.valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	// Monitor with a stall pattern that alternates quiet and busy stretches.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		out_item_t got;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if ((stall_phase / 200) % 2 == 0) out_ch.ready <= 1'b1;
			else out_ch.ready <= ($urandom_range(0, 3) != 0);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				checked++;
				if (expected.size() == 0) begin
					errors++;
					$display("MISMATCH unexpected result kind %0d at cycle %0d", got.kind, cycles);
				end else begin
					exp_r = expected.pop_front();
					if (got.kind != exp_r.kind) report("kind", got.kind, exp_r.kind);
					if (got.vert_x != exp_r.vert_x) report("vert_x", got.vert_x, exp_r.vert_x);
					if (got.vert_y != exp_r.vert_y) report("vert_y", got.vert_y, exp_r.vert_y);
					if (got.vert_z != exp_r.vert_z) report("vert_z", got.vert_z, exp_r.vert_z);
					if (got.corner != exp_r.corner) report("corner", got.corner, exp_r.corner);
					if (got.vert_color != exp_r.vert_color)
						report("vert_color", got.vert_color, exp_r.vert_color);
					if (got.slot != exp_r.slot) report("slot", got.slot, exp_r.slot);
					if (got.vert_tiling != exp_r.vert_tiling)
						report("vert_tiling", got.vert_tiling, exp_r.vert_tiling);
					if (got.bound_texture != exp_r.bound_texture)
						report("bound_texture", got.bound_texture, exp_r.bound_texture);
					if (got.index_count != exp_r.index_count)
						report("index_count", got.index_count, exp_r.index_count);
					if (got.last != exp_r.last) report("last", got.last, exp_r.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Timeout with %0d results outstanding", expected.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		errors = 0;
		checked = 0;
		quads_sent = 0;
		flushes_sent = 0;
		cycles = 0;
		stim_done = 0;
		used_slots = 1;
		quad_count = 0;
		for (int i = 0; i < 32; i++) tex_of_slot[i] = '0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (expected.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d quads and %0d scene flushes; %0d results checked.",
			quads_sent, flushes_sent, checked);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches found", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/qbvs_pkg.sv
sv/qbvs_if.sv
sv/qbvs_ctrl.sv
sv/qbvs_dp.sv
sv/quad_batch_vertex_setup.sv
bench/tb.sv
